@@ rtl/core/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and constants of the 3D vector unit
// Word format, stage map of the pipeline, opcodes, lane modes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

  // Number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_W      = 4;
  localparam int ANGLE_W   = 16;

  // Square root: sum of three squares, one result bit per step
  localparam int SQ_W       = 2 * WORD_BITS;
  localparam int ROOT_W     = WORD_BITS + 1;
  localparam int ROOT_STEPS = WORD_BITS;

  // Normalise divider: quotient never exceeds one, so FRAC_BITS+1 bits
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int REM_W     = ROOT_W + FRAC_BITS;

  // Sine and cosine
  localparam int TRIG_W       = 32;
  localparam int TRIG_SHIFT   = 30;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int ZETA_W       = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  // Lane arithmetic widths
  localparam int MULB_W = (WORD_BITS > TRIG_W) ? WORD_BITS : TRIG_W;
  localparam int PROD_W = WORD_BITS + MULB_W;
  localparam int VAL_W  = PROD_W + 2 - FRAC_BITS;
  localparam int ACC_W  = VAL_W + 2;

  // Stage map, counted in registers after the input transfer
  localparam int SQ_STAGE    = 1;
  localparam int ROOT_STAGE  = SQ_STAGE + 1 + ROOT_STEPS;
  localparam int MUL_STAGE   = ROOT_STAGE + DIV_STEPS + 1;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 2;
  localparam int CORDIC_TAP  = MUL_STAGE - 1 - CORDIC_LAT;
  localparam int LANE_STAGE  = MUL_STAGE + 1;
  localparam int LATENCY     = LANE_STAGE + 1;
  localparam int DLY_DEPTH   = LANE_STAGE + 1;
  localparam int ROOT_DLY    = LANE_STAGE - ROOT_STAGE;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_HADAMARD = 4'd2,
    OP_CROSS    = 4'd3,
    OP_DOT      = 4'd4,
    OP_MAG      = 4'd5,
    OP_NORM     = 4'd6,
    OP_ROTX     = 4'd7,
    OP_ROTY     = 4'd8,
    OP_ROTZ     = 4'd9
  } op_e;

  typedef enum logic [3:0] {
    LM_ZERO,
    LM_ADD,
    LM_SUB,
    LM_PROD,
    LM_DIFF,
    LM_ROTD,
    LM_ROTS,
    LM_PASS,
    LM_NORM
  } lane_mode_e;

  typedef struct packed {
    op_e                         op;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic [ANGLE_W-1:0]          angle;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] ma0;
    logic signed [MULB_W-1:0]    mb0;
    logic signed [WORD_BITS-1:0] ma1;
    logic signed [MULB_W-1:0]    mb1;
  } mul_op_t;

  typedef struct packed {
    lane_mode_e                  mode;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
  } lane_tail_t;

  typedef struct packed {
    logic                        sat;
    logic signed [WORD_BITS-1:0] value;
  } clamp_t;

  // Arctangent of 2^-i in binary angle units scaled by 2^16
  function automatic logic signed [ZETA_W-1:0] atan_turn(input int unsigned idx);
    case (idx)
      0:  return 32'sd536870912;
      1:  return 32'sd316933406;
      2:  return 32'sd167458907;
      3:  return 32'sd85004756;
      4:  return 32'sd42667331;
      5:  return 32'sd21354465;
      6:  return 32'sd10679838;
      7:  return 32'sd5340245;
      8:  return 32'sd2670163;
      9:  return 32'sd1335087;
      10: return 32'sd667544;
      11: return 32'sd333772;
      12: return 32'sd166886;
      13: return 32'sd83443;
      14: return 32'sd41722;
      15: return 32'sd20861;
      16: return 32'sd10430;
      17: return 32'sd5215;
      18: return 32'sd2608;
      19: return 32'sd1304;
      20: return 32'sd652;
      21: return 32'sd326;
      22: return 32'sd163;
      23: return 32'sd81;
      default: return '0;
    endcase
  endfunction

  // Component k of vector a or b
  function automatic logic signed [WORD_BITS-1:0] item_a(input item_t it,
                                                        input logic [1:0] k);
    case (k)
      2'd0:    return it.a_x;
      2'd1:    return it.a_y;
      default: return it.a_z;
    endcase
  endfunction

  function automatic logic signed [WORD_BITS-1:0] item_b(input item_t it,
                                                        input logic [1:0] k);
    case (k)
      2'd0:    return it.b_x;
      2'd1:    return it.b_y;
      default: return it.b_z;
    endcase
  endfunction

  // Clamp to the signed word range, flag when clamped
  function automatic clamp_t clamp_word(input logic signed [ACC_W-1:0] v);
    clamp_t                  r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi    = ACC_W'({(WORD_BITS-1){1'b1}});
    lo    = ~hi;
    r.sat = 1'b1;
    if (v > hi) begin
      r.value = hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      r.value = lo[WORD_BITS-1:0];
    end else begin
      r.sat   = 1'b0;
      r.value = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/v3a_isqrt.sv @@
// ----------------------------------------------------------------------------
// v3a_isqrt: pipelined integer square root of a sum of three squares
// One result bit per stage; a new operand may enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_isqrt (
  input  logic                        clk_i,
  input  logic [v3a_pkg::SQ_W-1:0]    sq0_i,
  input  logic [v3a_pkg::SQ_W-1:0]    sq1_i,
  input  logic [v3a_pkg::SQ_W-1:0]    sq2_i,
  output logic [v3a_pkg::ROOT_W-1:0]  root_o
);
  import v3a_pkg::*;

  logic [SQ_W-1:0] rem_q [ROOT_STEPS+1];
  logic [SQ_W-1:0] res_q [ROOT_STEPS+1];
  logic [SQ_W-1:0] rem_d [ROOT_STEPS];
  logic [SQ_W-1:0] res_d [ROOT_STEPS];

  // One bit-pair step per stage
  always_comb begin
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      bit_v = SQ_W'(1) << (SQ_W - 2 - 2 * i);
      trial = res_q[i] + bit_v;
      if (rem_q[i] >= trial) begin
        rem_d[i] = rem_q[i] - trial;
        res_d[i] = (res_q[i] >> 1) + bit_v;
      end else begin
        rem_d[i] = rem_q[i];
        res_d[i] = res_q[i] >> 1;
      end
    end
  end

  // Sum register, then the step registers
  always_ff @(posedge clk_i) begin
    rem_q[0] <= sq0_i + sq1_i + sq2_i;
    res_q[0] <= '0;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      rem_q[i+1] <= rem_d[i];
      res_q[i+1] <= res_d[i];
    end
  end

  assign root_o = res_q[ROOT_STEPS][ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/v3a_cordic.sv @@
// ----------------------------------------------------------------------------
// v3a_cordic: pipelined sine and cosine of a binary angle
// Quadrant reduction, fixed CORDIC steps in Q2.30, quadrant restore.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_cordic (
  input  logic                               clk_i,
  input  logic [v3a_pkg::ANGLE_W-1:0]        angle_i,
  output logic signed [v3a_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [v3a_pkg::TRIG_W-1:0]  sin_o
);
  import v3a_pkg::*;

  logic signed [CORDIC_W-1:0] x_q  [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q  [CORDIC_STEPS+1];
  logic signed [ZETA_W-1:0]   z_q  [CORDIC_STEPS+1];
  logic [1:0]                 qd_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] x_d  [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_d  [CORDIC_STEPS];
  logic signed [ZETA_W-1:0]   z_d  [CORDIC_STEPS];

  // Nearest quarter turn and the residual of at most an eighth turn
  logic [ANGLE_W-1:0] biased;
  logic [1:0]         quad;
  logic [ANGLE_W-1:0] resid;

  assign biased = angle_i + ANGLE_W'(1 << (ANGLE_W - 3));
  assign quad   = biased[ANGLE_W-1 -: 2];
  assign resid  = angle_i - {quad, {(ANGLE_W-2){1'b0}}};

  // Micro-rotations
  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z_q[i][ZETA_W-1]) begin
        x_d[i] = x_q[i] - (y_q[i] >>> i);
        y_d[i] = y_q[i] + (x_q[i] >>> i);
        z_d[i] = z_q[i] - atan_turn(i);
      end else begin
        x_d[i] = x_q[i] + (y_q[i] >>> i);
        y_d[i] = y_q[i] - (x_q[i] >>> i);
        z_d[i] = z_q[i] + atan_turn(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= CORDIC_GAIN_INV;
    y_q[0]  <= '0;
    z_q[0]  <= $signed({resid, {(ZETA_W-ANGLE_W){1'b0}}});
    qd_q[0] <= quad;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      x_q[i+1]  <= x_d[i];
      y_q[i+1]  <= y_d[i];
      z_q[i+1]  <= z_d[i];
      qd_q[i+1] <= qd_q[i];
    end
  end

  // Put the quadrant back by swap and negation
  logic signed [CORDIC_W-1:0] cos_d;
  logic signed [CORDIC_W-1:0] sin_d;

  always_comb begin
    case (qd_q[CORDIC_STEPS])
      2'd0: begin
        cos_d = x_q[CORDIC_STEPS];
        sin_d = y_q[CORDIC_STEPS];
      end
      2'd1: begin
        cos_d = -y_q[CORDIC_STEPS];
        sin_d = x_q[CORDIC_STEPS];
      end
      2'd2: begin
        cos_d = -x_q[CORDIC_STEPS];
        sin_d = -y_q[CORDIC_STEPS];
      end
      default: begin
        cos_d = y_q[CORDIC_STEPS];
        sin_d = -x_q[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cos_o <= TRIG_W'(cos_d);
    sin_o <= TRIG_W'(sin_d);
  end

endmodule

`default_nettype wire

@@ rtl/core/v3a_lane.sv @@
// ----------------------------------------------------------------------------
// v3a_lane: one component lane of the 3D vector unit
// Squares its component, divides it by the magnitude, and forms the
// component result from the products, the quotient or the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_lane (
  input  logic                                 clk_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] sq_a_i,
  output logic [v3a_pkg::SQ_W-1:0]             sq_o,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] div_a_i,
  input  logic [v3a_pkg::ROOT_W-1:0]           root_i,
  input  v3a_pkg::mul_op_t                     mul_i,
  input  v3a_pkg::lane_tail_t                  tail_i,
  output logic signed [v3a_pkg::VAL_W-1:0]     val_o
);
  import v3a_pkg::*;

  // Square of the magnitude of the component
  logic [WORD_BITS-1:0] sq_mag;

  assign sq_mag = sq_a_i[WORD_BITS-1] ? WORD_BITS'(-sq_a_i) : WORD_BITS'(sq_a_i);

  always_ff @(posedge clk_i) begin
    sq_o <= sq_mag * sq_mag;
  end

  // Restoring divider: |a| * 2^FRAC / root, one quotient bit per stage
  logic [REM_W-1:0]     rem_q [DIV_STEPS+1];
  logic [ROOT_W-1:0]    dvs_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];
  logic                 zro_q [DIV_STEPS+1];
  logic [REM_W-1:0]     rem_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_d [DIV_STEPS];
  logic [WORD_BITS-1:0] div_mag;

  assign div_mag = div_a_i[WORD_BITS-1] ? WORD_BITS'(-div_a_i) : WORD_BITS'(div_a_i);

  always_comb begin
    logic [REM_W-1:0] trial;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = REM_W'(dvs_q[j]) << (DIV_STEPS - 1 - j);
      if (rem_q[j] >= trial) begin
        rem_d[j] = rem_q[j] - trial;
        quo_d[j] = {quo_q[j][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d[j] = rem_q[j];
        quo_d[j] = {quo_q[j][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= REM_W'({div_mag, {FRAC_BITS{1'b0}}});
    dvs_q[0] <= root_i;
    quo_q[0] <= '0;
    neg_q[0] <= div_a_i[WORD_BITS-1];
    zro_q[0] <= (root_i == '0);
    for (int j = 0; j < DIV_STEPS; j++) begin
      rem_q[j+1] <= rem_d[j];
      dvs_q[j+1] <= dvs_q[j];
      quo_q[j+1] <= quo_d[j];
      neg_q[j+1] <= neg_q[j];
      zro_q[j+1] <= zro_q[j];
    end
  end

  // Two products per lane
  logic signed [PROD_W-1:0] m0_q;
  logic signed [PROD_W-1:0] m1_q;

  always_ff @(posedge clk_i) begin
    m0_q <= $signed(mul_i.ma0) * $signed(mul_i.mb0);
    m1_q <= $signed(mul_i.ma1) * $signed(mul_i.mb1);
  end

  // Component result
  logic signed [PROD_W:0]   pdiff;
  logic signed [PROD_W:0]   psum;
  logic signed [VAL_W-1:0]  nq;
  logic signed [VAL_W-1:0]  val_d;
  logic signed [VAL_W-1:0]  val_q;

  assign pdiff = (PROD_W+1)'(m0_q) - (PROD_W+1)'(m1_q);
  assign psum  = (PROD_W+1)'(m0_q) + (PROD_W+1)'(m1_q);
  assign nq    = $signed(VAL_W'(quo_q[DIV_STEPS]));

  always_comb begin
    case (tail_i.mode)
      LM_ADD:  val_d = VAL_W'($signed(tail_i.a)) + VAL_W'($signed(tail_i.b));
      LM_SUB:  val_d = VAL_W'($signed(tail_i.a)) - VAL_W'($signed(tail_i.b));
      LM_PROD: val_d = VAL_W'(m0_q >>> FRAC_BITS);
      LM_DIFF: val_d = VAL_W'(pdiff >>> FRAC_BITS);
      LM_ROTD: val_d = VAL_W'(pdiff >>> TRIG_SHIFT);
      LM_ROTS: val_d = VAL_W'(psum >>> TRIG_SHIFT);
      LM_PASS: val_d = VAL_W'($signed(tail_i.a));
      LM_NORM: begin
        if (zro_q[DIV_STEPS]) begin
          val_d = '0;
        end else begin
          val_d = neg_q[DIV_STEPS] ? -nq : nq;
        end
      end
      default: val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

@@ rtl/core/vector3_alu_unit.sv @@
// ----------------------------------------------------------------------------
// vector3_alu_unit: fixed-point 3D vector unit, signed Q16.16
// Three component lanes, a shared root and a shared sine/cosine pipeline,
// and a merge stage that clamps and flags the results.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   busy stays low: a new command may be issued in every cycle.
//   Each command gives one result, shown on result_*_o and saturated_o for
//   exactly one cycle with done_o high. Throughput is one command per cycle.
//   The latency is set by the chain square, 32-stage square root, 17-stage
//   normalise divider, product and merge; all operations run through the
//   same fixed-length pipeline, so results leave in command order.
//   The receiver cannot stall; results must be taken when done_o is high.
//   Reset clears the pipeline valid bits: no result appears for commands
//   in flight at reset. Payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [v3a_pkg::OP_W-1:0]             operation_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] a_x_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] a_y_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] a_z_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] b_x_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] b_y_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0] b_z_i,
  input  logic [v3a_pkg::ANGLE_W-1:0]          angle_i,
  output logic                                 done_o,
  output logic signed [v3a_pkg::WORD_BITS-1:0] result_x_o,
  output logic signed [v3a_pkg::WORD_BITS-1:0] result_y_o,
  output logic signed [v3a_pkg::WORD_BITS-1:0] result_z_o,
  output logic signed [v3a_pkg::WORD_BITS-1:0] result_scalar_o,
  output logic                                 saturated_o
);
  import v3a_pkg::*;

  assign busy = 1'b0;

  // Command delay line and valid bits
  item_t              dly_q [DLY_DEPTH];
  logic [LATENCY:0]   vld_q;

  always_ff @(posedge clk_i) begin
    dly_q[0].op    <= op_e'(operation_i);
    dly_q[0].a_x   <= a_x_i;
    dly_q[0].a_y   <= a_y_i;
    dly_q[0].a_z   <= a_z_i;
    dly_q[0].b_x   <= b_x_i;
    dly_q[0].b_y   <= b_y_i;
    dly_q[0].b_z   <= b_z_i;
    dly_q[0].angle <= angle_i;
    for (int k = 1; k < DLY_DEPTH; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-1:0], start & ~busy};
    end
  end

  assign done_o = vld_q[LATENCY];

  // Sine and cosine, aligned with the product stage
  logic signed [TRIG_W-1:0] cos_w;
  logic signed [TRIG_W-1:0] sin_w;

  v3a_cordic u_cordic (
    .clk_i   (clk_i),
    .angle_i (dly_q[CORDIC_TAP].angle),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // Lanes
  logic [SQ_W-1:0]         sq_w     [3];
  logic signed [VAL_W-1:0] lane_val [3];
  mul_op_t                 mul_op   [3];
  lane_tail_t              tail     [3];
  logic [ROOT_W-1:0]       root_w;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    v3a_lane u_lane (
      .clk_i   (clk_i),
      .sq_a_i  (item_a(dly_q[0], 2'(k))),
      .sq_o    (sq_w[k]),
      .div_a_i (item_a(dly_q[ROOT_STAGE], 2'(k))),
      .root_i  (root_w),
      .mul_i   (mul_op[k]),
      .tail_i  (tail[k]),
      .val_o   (lane_val[k])
    );
  end

  v3a_isqrt u_isqrt (
    .clk_i  (clk_i),
    .sq0_i  (sq_w[0]),
    .sq1_i  (sq_w[1]),
    .sq2_i  (sq_w[2]),
    .root_o (root_w)
  );

  // Magnitude carried on to the merge stage
  logic [ROOT_W-1:0] rd_q [ROOT_DLY];

  always_ff @(posedge clk_i) begin
    rd_q[0] <= root_w;
    for (int k = 1; k < ROOT_DLY; k++) begin
      rd_q[k] <= rd_q[k-1];
    end
  end

  // Multiplier operand routing
  always_comb begin
    item_t                    it;
    logic signed [MULB_W-1:0] c;
    logic signed [MULB_W-1:0] s;
    it = dly_q[MUL_STAGE-1];
    c  = MULB_W'(cos_w);
    s  = MULB_W'(sin_w);
    for (int k = 0; k < 3; k++) begin
      mul_op[k] = '0;
    end
    unique case (it.op) inside
      OP_HADAMARD, OP_DOT: begin
        mul_op[0] = '{ma0: it.a_x, mb0: MULB_W'(it.b_x), ma1: '0, mb1: '0};
        mul_op[1] = '{ma0: it.a_y, mb0: MULB_W'(it.b_y), ma1: '0, mb1: '0};
        mul_op[2] = '{ma0: it.a_z, mb0: MULB_W'(it.b_z), ma1: '0, mb1: '0};
      end
      OP_CROSS: begin
        mul_op[0] = '{ma0: it.a_y, mb0: MULB_W'(it.b_z),
                      ma1: it.a_z, mb1: MULB_W'(it.b_y)};
        mul_op[1] = '{ma0: it.a_z, mb0: MULB_W'(it.b_x),
                      ma1: it.a_x, mb1: MULB_W'(it.b_z)};
        mul_op[2] = '{ma0: it.a_x, mb0: MULB_W'(it.b_y),
                      ma1: it.a_y, mb1: MULB_W'(it.b_x)};
      end
      OP_ROTX: begin
        mul_op[1] = '{ma0: it.a_y, mb0: c, ma1: it.a_z, mb1: s};
        mul_op[2] = '{ma0: it.a_y, mb0: s, ma1: it.a_z, mb1: c};
      end
      OP_ROTY: begin
        mul_op[2] = '{ma0: it.a_z, mb0: c, ma1: it.a_x, mb1: s};
        mul_op[0] = '{ma0: it.a_z, mb0: s, ma1: it.a_x, mb1: c};
      end
      OP_ROTZ: begin
        mul_op[0] = '{ma0: it.a_x, mb0: c, ma1: it.a_y, mb1: s};
        mul_op[1] = '{ma0: it.a_x, mb0: s, ma1: it.a_y, mb1: c};
      end
      default: ;
    endcase
  end

  // Lane mode decode
  always_comb begin
    item_t it;
    it = dly_q[MUL_STAGE];
    for (int k = 0; k < 3; k++) begin
      tail[k].a    = item_a(it, 2'(k));
      tail[k].b    = item_b(it, 2'(k));
      tail[k].mode = LM_ZERO;
    end
    unique case (it.op) inside
      OP_ADD: begin
        for (int k = 0; k < 3; k++) tail[k].mode = LM_ADD;
      end
      OP_SUB: begin
        for (int k = 0; k < 3; k++) tail[k].mode = LM_SUB;
      end
      OP_HADAMARD, OP_DOT: begin
        for (int k = 0; k < 3; k++) tail[k].mode = LM_PROD;
      end
      OP_CROSS: begin
        for (int k = 0; k < 3; k++) tail[k].mode = LM_DIFF;
      end
      OP_NORM: begin
        for (int k = 0; k < 3; k++) tail[k].mode = LM_NORM;
      end
      OP_ROTX: begin
        tail[0].mode = LM_PASS;
        tail[1].mode = LM_ROTD;
        tail[2].mode = LM_ROTS;
      end
      OP_ROTY: begin
        tail[1].mode = LM_PASS;
        tail[2].mode = LM_ROTD;
        tail[0].mode = LM_ROTS;
      end
      OP_ROTZ: begin
        tail[2].mode = LM_PASS;
        tail[0].mode = LM_ROTD;
        tail[1].mode = LM_ROTS;
      end
      default: ;
    endcase
  end

  // Merge: scalar result, clamping and flag
  clamp_t cx;
  clamp_t cy;
  clamp_t cz;
  clamp_t cs;

  always_comb begin
    logic signed [ACC_W-1:0] vx;
    logic signed [ACC_W-1:0] vy;
    logic signed [ACC_W-1:0] vz;
    logic signed [ACC_W-1:0] scal;
    vx   = ACC_W'(lane_val[0]);
    vy   = ACC_W'(lane_val[1]);
    vz   = ACC_W'(lane_val[2]);
    scal = '0;
    unique case (dly_q[LANE_STAGE].op) inside
      OP_DOT: begin
        scal = vx + vy + vz;
        vx   = '0;
        vy   = '0;
        vz   = '0;
      end
      OP_MAG: begin
        scal = ACC_W'(rd_q[ROOT_DLY-1]);
      end
      default: ;
    endcase
    cx = clamp_word(vx);
    cy = clamp_word(vy);
    cz = clamp_word(vz);
    cs = clamp_word(scal);
  end

  always_ff @(posedge clk_i) begin
    result_x_o      <= cx.value;
    result_y_o      <= cy.value;
    result_z_o      <= cz.value;
    result_scalar_o <= cs.value;
    saturated_o     <= cx.sat | cy.sat | cz.sat | cs.sat;
  end

  // Assertions: done_o is seen at the edge that ends its cycle
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(LATENCY+1) done_o)
    else $error("result missing after a command transfer");

  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY+1))
    else $error("result without a matching command");

  a_norm_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LANE_STAGE] && dly_q[LANE_STAGE].op == OP_NORM) |->
      (lane_val[0] <= $signed(VAL_W'(1 << FRAC_BITS)) &&
       lane_val[0] >= -$signed(VAL_W'(1 << FRAC_BITS)) &&
       lane_val[2] <= $signed(VAL_W'(1 << FRAC_BITS)) &&
       lane_val[2] >= -$signed(VAL_W'(1 << FRAC_BITS))))
    else $error("normalised component beyond one");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_alu_unit
// Commands are driven at the falling edge with random gaps. Every transfer
// is run through a bit-exact software model of the vector unit, and each
// done_o strobe is compared with the oldest outstanding prediction. A short
// directed table comes first, then about 2000 random commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import v3a_pkg::*;

  localparam int  N_RANDOM   = 2000;
  localparam int  IDLE_LIMIT = 2000;
  localparam int  DRAIN      = 64;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic               sat;
  } vec_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [15:0]        ang;
    logic               typed;
    vec_result_t        res;
  } cmd_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    operation_i;
  logic signed [31:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i;
  logic [15:0]        angle_i;
  logic               done_o;
  logic signed [31:0] result_x_o, result_y_o, result_z_o, result_scalar_o;
  logic               saturated_o;

  vec_result_t pending_results[$];
  vec_result_t typed_results[$];
  logic        use_typed[$];
  int          fail_count;
  int          idle_cycles;
  cmd_row_t    directed[$];

  vector3_alu_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .angle_i,
    .done_o, .result_x_o, .result_y_o, .result_z_o, .result_scalar_o,
    .saturated_o
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // ---------------------------------------------------------------- model
  function automatic wide_t floor_shr(wide_t v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] sat_word(wide_t v, inout logic flag);
    if (v > wide_t'(W_MAX)) begin
      flag = 1'b1;
      return W_MAX;
    end
    if (v < wide_t'(W_MIN)) begin
      flag = 1'b1;
      return W_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] bitv;
    r    = '0;
    bitv = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sq_mag(logic signed [31:0] v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-wide_t'(v)) : 64'(v);
    return m * m;
  endfunction

  // cosine and sine in Q2.30 from a quadrant fold and a 24-step CORDIC
  task automatic trig_q30(logic [15:0] ang, output wide_t c, output wide_t s);
    logic [1:0]  quad;
    logic [15:0] resid;
    wide_t       r, x, y, z, xn;
    quad  = 2'((32'(ang) + 32'h2000) >> 14);
    resid = ang - 16'(quad) * 16'h4000;
    r     = wide_t'(resid);
    if (r >= 32768) r = r - 65536;
    x = wide_t'(CORDIC_GAIN_INV);
    y = 0;
    z = r * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        xn = x - floor_shr(y, i);
        y  = y + floor_shr(x, i);
        z  = z - wide_t'(atan_turn(i));
      end else begin
        xn = x + floor_shr(y, i);
        y  = y - floor_shr(x, i);
        z  = z + wide_t'(atan_turn(i));
      end
      x = xn;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_vector(cmd_row_t t, output vec_result_t res);
    wide_t       ax, ay, az, bx, by, bz, rx, ry, rz, rs, c, s, one;
    logic [63:0] mag;
    logic        flag;
    ax = t.ax; ay = t.ay; az = t.az;
    bx = t.bx; by = t.by; bz = t.bz;
    rx = 0; ry = 0; rz = 0; rs = 0; flag = 1'b0;
    one = wide_t'(1) << FRAC_BITS;
    case (t.op)
      OP_ADD: begin rx = ax + bx; ry = ay + by; rz = az + bz; end
      OP_SUB: begin rx = ax - bx; ry = ay - by; rz = az - bz; end
      OP_HADAMARD: begin
        rx = floor_shr(ax * bx, FRAC_BITS);
        ry = floor_shr(ay * by, FRAC_BITS);
        rz = floor_shr(az * bz, FRAC_BITS);
      end
      OP_CROSS: begin
        rx = floor_shr(ay * bz - az * by, FRAC_BITS);
        ry = floor_shr(az * bx - ax * bz, FRAC_BITS);
        rz = floor_shr(ax * by - ay * bx, FRAC_BITS);
      end
      OP_DOT: rs = floor_shr(ax * bx, FRAC_BITS) + floor_shr(ay * by, FRAC_BITS)
                 + floor_shr(az * bz, FRAC_BITS);
      OP_MAG: begin
        mag = int_root(sq_mag(t.ax) + sq_mag(t.ay) + sq_mag(t.az));
        rs  = wide_t'(mag);
      end
      OP_NORM: begin
        mag = int_root(sq_mag(t.ax) + sq_mag(t.ay) + sq_mag(t.az));
        if (mag == 0) begin
          rx = ax; ry = ay; rz = az;
        end else begin
          rx = (ax * one) / wide_t'(mag);
          ry = (ay * one) / wide_t'(mag);
          rz = (az * one) / wide_t'(mag);
        end
      end
      OP_ROTX: begin
        trig_q30(t.ang, c, s);
        rx = ax;
        ry = floor_shr(ay * c - az * s, TRIG_SHIFT);
        rz = floor_shr(ay * s + az * c, TRIG_SHIFT);
      end
      OP_ROTY: begin
        trig_q30(t.ang, c, s);
        ry = ay;
        rz = floor_shr(az * c - ax * s, TRIG_SHIFT);
        rx = floor_shr(az * s + ax * c, TRIG_SHIFT);
      end
      OP_ROTZ: begin
        trig_q30(t.ang, c, s);
        rz = az;
        rx = floor_shr(ax * c - ay * s, TRIG_SHIFT);
        ry = floor_shr(ax * s + ay * c, TRIG_SHIFT);
      end
      default: ;
    endcase
    res.x   = sat_word(rx, flag);
    res.y   = sat_word(ry, flag);
    res.z   = sat_word(rz, flag);
    res.s   = sat_word(rs, flag);
    res.sat = flag;
  endtask

  // ---------------------------------------------------------------- scoreboard
  // record a prediction at each command transfer
  always @(posedge clk_i) begin
    cmd_row_t    t;
    vec_result_t r;
    if (rst_ni && start && !busy) begin
      t.op = operation_i;
      t.ax = a_x_i; t.ay = a_y_i; t.az = a_z_i;
      t.bx = b_x_i; t.by = b_y_i; t.bz = b_z_i;
      t.ang = angle_i;
      predict_vector(t, r);
      if (use_typed.size() != 0 && use_typed.pop_front()) r = typed_results.pop_front();
      pending_results.push_back(r);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    vec_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h s=%h sat=%b", $time,
                 result_x_o, result_y_o, result_z_o, result_scalar_o, saturated_o);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_x_o !== e.x) begin
          $display("%0t: result_x exp %h got %h", $time, e.x, result_x_o);
          fail_count++;
        end
        if (result_y_o !== e.y) begin
          $display("%0t: result_y exp %h got %h", $time, e.y, result_y_o);
          fail_count++;
        end
        if (result_z_o !== e.z) begin
          $display("%0t: result_z exp %h got %h", $time, e.z, result_z_o);
          fail_count++;
        end
        if (result_scalar_o !== e.s) begin
          $display("%0t: result_scalar exp %h got %h", $time, e.s, result_scalar_o);
          fail_count++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_cmd(cmd_row_t t);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    use_typed.push_back(t.typed);
    if (t.typed) typed_results.push_back(t.res);
    start       <= 1'b1;
    operation_i <= t.op;
    a_x_i <= t.ax; a_y_i <= t.ay; a_z_i <= t.az;
    b_x_i <= t.bx; b_y_i <= t.by; b_z_i <= t.bz;
    angle_i <= t.ang;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return 32'($signed(16'($urandom)));
      3:       return 32'($signed(20'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_row_t row(logic [OP_W-1:0] op, logic signed [31:0] ax,
                                   logic signed [31:0] ay, logic signed [31:0] az,
                                   logic signed [31:0] bx, logic signed [31:0] by,
                                   logic signed [31:0] bz, logic [15:0] ang);
    cmd_row_t t;
    t.op = op; t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz; t.ang = ang;
    t.typed = 1'b0;
    t.res   = '{0, 0, 0, 0, 1'b0};
    return t;
  endfunction

  function automatic cmd_row_t typed_row(cmd_row_t t, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z,
                                         logic signed [31:0] s, logic sat);
    t.typed = 1'b1;
    t.res   = '{x, y, z, s, sat};
    return t;
  endfunction

  initial begin
    cmd_row_t t;
    fail_count  = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = OP_ADD;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i} = '0;
    angle_i     = '0;

    // directed table: extremes, every opcode, zero normalise, spare opcodes
    directed.push_back(typed_row(row(OP_ADD, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_ADD, W_MAX, W_MIN, 1, W_MAX, W_MIN, -1, 0),
                                 W_MAX, W_MIN, 0, 0, 1));
    directed.push_back(typed_row(row(OP_SUB, W_MIN, W_MAX, 5, W_MAX, W_MIN, 5, 0),
                                 W_MIN, W_MAX, 0, 0, 1));
    directed.push_back(row(OP_HADAMARD, W_MIN, W_MAX, -3, W_MIN, W_MIN, 7, 0));
    directed.push_back(row(OP_CROSS, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, 0));
    directed.push_back(row(OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0));
    directed.push_back(row(OP_DOT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0));
    directed.push_back(row(OP_DOT, -1, 1, -1, 1, 1, 1, 0));
    directed.push_back(row(OP_MAG, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0));
    directed.push_back(row(OP_MAG, 32'h30000, 32'h40000, 0, 9, 9, 9, 0));
    directed.push_back(typed_row(row(OP_NORM, 0, 0, 0, W_MAX, W_MIN, 1, 16'hFFFF),
                                 0, 0, 0, 0, 0));
    directed.push_back(row(OP_NORM, W_MIN, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_NORM, 1, -1, 1, 0, 0, 0, 0));
    directed.push_back(row(OP_ROTX, 32'h10000, 32'h10000, 0, 0, 0, 0, 16'h4000));
    directed.push_back(row(OP_ROTX, W_MAX, W_MIN, W_MIN, 0, 0, 0, 16'h2000));
    directed.push_back(row(OP_ROTY, 32'h10000, 0, 32'h20000, 0, 0, 0, 16'h1FFF));
    directed.push_back(row(OP_ROTY, W_MIN, W_MAX, W_MIN, 0, 0, 0, 16'h6000));
    directed.push_back(row(OP_ROTZ, 32'h10000, 32'h10000, 0, 0, 0, 0, 16'h8000));
    directed.push_back(row(OP_ROTZ, W_MAX, W_MAX, 1, 0, 0, 0, 16'hFFFF));
    directed.push_back(row(OP_ROTZ, W_MIN, W_MIN, 1, 0, 0, 0, 16'hE000));
    directed.push_back(row(OP_ROTX, 32'h12345, -7, 99, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_SPARE_LO, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                                     W_MAX, 16'h1234), 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_SPARE_HI, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                                     W_MIN, 16'hFFFF), 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_cmd(directed[i]);

    // random commands, mostly valid opcodes
    for (int n = 0; n < N_RANDOM; n++) begin
      t = row(($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9)),
              rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
      if ($urandom_range(0, 9) == 0) {t.ax, t.ay, t.az} = '0;
      send_cmd(t);
    end
    @(negedge clk_i);
    start <= 1'b0;

    // drain the pipeline
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
